### rtl/assert_macros.svh
// Assertion helpers for the RTL; base64_codec_unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define B64C_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define B64C_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

### rtl/b64c_pkg.sv
`default_nettype none

package b64c_pkg;

  localparam int unsigned BurstDepth = 4;
  localparam int unsigned CntWidth   = $clog2(BurstDepth + 1);
  localparam int unsigned PtrWidth   = $clog2(BurstDepth);

  localparam logic [7:0] PadChar = 8'h3d;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharLf    = 8'h0a;
  localparam logic [7:0] CharVt    = 8'h0b;
  localparam logic [7:0] CharFf    = 8'h0c;
  localparam logic [7:0] CharCr    = 8'h0d;

  localparam logic RegEncodeMode = 1'b0;

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_DATA = 3'd1,
    PH_PAD2 = 3'd2,
    PH_TAIL = 3'd3,
    PH_DONE = 3'd4
  } b64c_phase_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BADCHAR    = 3'd1,
    ST_PAD        = 3'd2,
    ST_INCOMPLETE = 3'd3,
    ST_LEFTOVER   = 3'd4
  } b64c_status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } b64c_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic [2:0] status;
  } b64c_out_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } b64c_sextet_t;

  // Six-bit value to alphabet character.
  function automatic logic [7:0] enc_char(logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)      return w + 8'd65;
    else if (v < 6'd52) return w + 8'd71;
    else if (v < 6'd62) return w - 8'd4;
    else if (v == 6'd62) return 8'h2b;
    else                return 8'h2f;
  endfunction

  // Alphabet character to six-bit value; ok is low for anything else.
  function automatic b64c_sextet_t dec_char(logic [7:0] c);
    b64c_sextet_t r;
    r.ok    = 1'b1;
    r.value = '0;
    if (c >= 8'h41 && c <= 8'h5a)      r.value = 6'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7a) r.value = 6'(c - 8'h47);
    else if (c >= 8'h30 && c <= 8'h39) r.value = 6'(c + 8'h04);
    else if (c == 8'h2b)               r.value = 6'd62;
    else if (c == 8'h2f)               r.value = 6'd63;
    else                               r.ok    = 1'b0;
    return r;
  endfunction

  // Status after the end-of-text check; the first error found stays.
  function automatic b64c_status_e end_err(b64c_phase_e ph, logic [1:0] gp,
                                           logic [7:0] pb, b64c_status_e err);
    b64c_status_e code;
    code = ST_OK;
    if (ph == PH_DATA && gp != 2'd0)   code = ST_INCOMPLETE;
    else if (ph == PH_PAD2)            code = ST_INCOMPLETE;
    else if (ph == PH_TAIL && pb != 8'h00) code = ST_LEFTOVER;
    if (err == ST_OK) return code;
    return err;
  endfunction

  function automatic b64c_status_e first_err(b64c_status_e err, b64c_status_e code);
    if (err == ST_OK) return code;
    return err;
  endfunction

endpackage

`default_nettype wire

### rtl/base64_codec_unit.sv
// Streaming Base64 codec. The encode_mode register (byte address 0, reset 1)
// selects encoding of raw bytes into alphabet characters, or decoding of Base64
// text back into bytes; writing it also clears all message state, and it must
// only be written while the unit is idle. Each accepted input word is worked
// on in the cycle it is accepted: all of its results (none to four) are formed
// by one pass of logic and written into a four-entry burst register, from
// which an output register hands out one result word per cycle while the
// receiver takes them. A new input word is taken as soon as the burst
// register drains to its last entry, so an input that gives several results
// holds the input channel until all but the last of them are handed out.
// Encoding gives four characters for every three bytes: the two bytes that
// are only gathered give no results and the byte that completes the group
// gives all four. Decoding gives at most two results per character and
// usually one, so when the output is not stalled it runs at about one
// character per cycle. The input waits while more than one result is still
// queued in the burst register, and that is what sets the rate. When encoding,
// a message whose length is not a multiple of three is zero-filled and padded
// with '='. When decoding, every message ends with a status-only word
// (out_valid low, out_last high) whose status field reports 0 ok, 1 bad
// character, 2 misplaced pad, 3 incomplete quantum or 4 nonzero leftover bits;
// bytes emitted before an error are not withdrawn.
`default_nettype none

`include "assert_macros.svh"

module base64_codec_unit
  import b64c_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire b64c_in_t    in_word_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      b64c_out_t   out_word_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  // Configuration and message state.
  logic         mode_q;
  logic [15:0]  held_q, held_d;
  logic [1:0]   gp_q, gp_d;
  logic [7:0]   pb_q, pb_d;
  b64c_phase_e  ph_q, ph_d;
  b64c_status_e err_q, err_d;

  // Burst register holding the results of the latest input word.
  b64c_out_t             burst_q [BurstDepth];
  logic [CntWidth-1:0]   cnt_q;
  logic [PtrWidth-1:0]   head_q;

  // Output register.
  logic       out_vld_q;
  b64c_out_t  out_q;

  b64c_out_t             res [BurstDepth];
  logic [CntWidth-1:0]   res_n;

  logic in_acc, load, cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegEncodeMode);
  assign prdata = (paddr[2] == RegEncodeMode) ? {31'b0, mode_q} : 32'b0;

  // A result moves from the burst register to the output register when the
  // output register is empty or its word is being taken.
  assign load       = (cnt_q != '0) && (!out_vld_q || out_ready_i);
  assign in_ready_o = (cnt_q == '0) || ((cnt_q == CntWidth'(1)) && load);
  assign in_acc     = in_valid_i && in_ready_o;

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  // Single pass over one input word: next message state and its results.
  always_comb begin
    logic [7:0]   c;
    logic [1:0]   cnt;
    logic [7:0]   b0, b1, b2;
    logic         blank, other;
    b64c_phase_e  cur;
    b64c_sextet_t sx;

    c     = in_word_i.in_byte;
    cnt   = 2'd0;
    b0    = '0;
    b1    = '0;
    b2    = '0;
    blank = (c == CharSpace) || (c == CharTab);
    other = (c == CharLf) || (c == CharVt) || (c == CharFf) || (c == CharCr);
    cur   = ph_q;
    sx    = dec_char(c);

    held_d = held_q;
    gp_d   = gp_q;
    pb_d   = pb_q;
    ph_d   = ph_q;
    err_d  = err_q;
    res_n  = '0;
    for (int i = 0; i < BurstDepth; i++) begin
      res[i] = '0;
    end

    if (mode_q) begin
      // Encoder: count is the number of bytes in the group with this one.
      cnt = (gp_q >= 2'd2) ? 2'd3 : gp_q + 2'd1;
      if (cnt != 2'd3 && !in_word_i.in_last) begin
        held_d = {held_q[7:0], c};
        gp_d   = cnt;
      end else begin
        case (cnt)
          2'd1: begin
            b0 = c;
          end
          2'd2: begin
            b0 = held_q[7:0];
            b1 = c;
          end
          default: begin
            b0 = held_q[15:8];
            b1 = held_q[7:0];
            b2 = c;
          end
        endcase
        res[0].out_byte  = enc_char(b0[7:2]);
        res[1].out_byte  = enc_char({b0[1:0], b1[7:4]});
        res[2].out_byte  = (cnt != 2'd1) ? enc_char({b1[3:0], b2[7:6]}) : PadChar;
        res[3].out_byte  = (cnt == 2'd3) ? enc_char(b2[5:0]) : PadChar;
        res[0].out_valid = 1'b1;
        res[1].out_valid = 1'b1;
        res[2].out_valid = 1'b1;
        res[3].out_valid = 1'b1;
        res[3].out_last  = in_word_i.in_last;
        res_n  = CntWidth'(BurstDepth);
        held_d = '0;
        gp_d   = '0;
        if (in_word_i.in_last) begin
          pb_d  = '0;
          ph_d  = PH_LEAD;
          err_d = ST_OK;
        end
      end
    end else begin
      // Decoder: one character.
      if (ph_q != PH_DONE) begin
        if (ph_q == PH_LEAD && blank) begin
          ph_d = PH_LEAD;
        end else if (ph_q == PH_LEAD && c == CharNul) begin
          err_d = end_err(ph_q, gp_q, pb_q, err_q);
          ph_d  = PH_DONE;
        end else begin
          if (ph_q == PH_LEAD) begin
            cur = PH_DATA;
          end
          ph_d = cur;
          if (blank || c == CharNul) begin
            err_d = end_err(cur, gp_q, pb_q, err_q);
            ph_d  = PH_DONE;
          end else if (other) begin
            ph_d = cur;
          end else if (cur == PH_PAD2) begin
            if (c == PadChar) begin
              ph_d = PH_TAIL;
            end else begin
              err_d = first_err(err_q, ST_PAD);
              ph_d  = PH_DONE;
            end
          end else if (cur == PH_TAIL) begin
            err_d = first_err(err_q, ST_PAD);
            ph_d  = PH_DONE;
          end else if (c == PadChar) begin
            if (gp_q == 2'd2) begin
              ph_d = PH_PAD2;
            end else if (gp_q == 2'd3) begin
              ph_d = PH_TAIL;
            end else begin
              err_d = first_err(err_q, ST_PAD);
              ph_d  = PH_DONE;
            end
          end else if (!sx.ok) begin
            err_d = first_err(err_q, ST_BADCHAR);
            ph_d  = PH_DONE;
          end else begin
            case (gp_q)
              2'd0: begin
                pb_d = {sx.value, 2'b00};
                gp_d = 2'd1;
              end
              2'd1: begin
                res[0].out_byte  = pb_q | {6'b0, sx.value[5:4]};
                res[0].out_valid = 1'b1;
                res_n = CntWidth'(1);
                pb_d  = {sx.value[3:0], 4'b0};
                gp_d  = 2'd2;
              end
              2'd2: begin
                res[0].out_byte  = pb_q | {4'b0, sx.value[5:2]};
                res[0].out_valid = 1'b1;
                res_n = CntWidth'(1);
                pb_d  = {sx.value[1:0], 6'b0};
                gp_d  = 2'd3;
              end
              default: begin
                res[0].out_byte  = pb_q | {2'b0, sx.value};
                res[0].out_valid = 1'b1;
                res_n = CntWidth'(1);
                pb_d  = '0;
                gp_d  = 2'd0;
              end
            endcase
          end
        end
      end
      // End of message: final check, status word, fresh state.
      if (in_word_i.in_last) begin
        if (ph_d != PH_DONE) begin
          err_d = end_err(ph_d, gp_d, pb_d, err_d);
        end
        res[res_n[PtrWidth-1:0]].out_last = 1'b1;
        res[res_n[PtrWidth-1:0]].status   = err_d;
        res_n  = res_n + CntWidth'(1);
        held_d = '0;
        gp_d   = '0;
        pb_d   = '0;
        ph_d   = PH_LEAD;
        err_d  = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      held_q <= '0;
      gp_q   <= '0;
      pb_q   <= '0;
      ph_q   <= PH_LEAD;
      err_q  <= ST_OK;
    end else if (cfg_wr) begin
      mode_q <= pwdata[0];
      held_q <= '0;
      gp_q   <= '0;
      pb_q   <= '0;
      ph_q   <= PH_LEAD;
      err_q  <= ST_OK;
    end else if (in_acc) begin
      held_q <= held_d;
      gp_q   <= gp_d;
      pb_q   <= pb_d;
      ph_q   <= ph_d;
      err_q  <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      head_q <= '0;
    end else if (in_acc) begin
      cnt_q  <= res_n;
      head_q <= '0;
    end else if (load) begin
      cnt_q  <= cnt_q - CntWidth'(1);
      head_q <= head_q + PtrWidth'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < BurstDepth; i++) begin
        burst_q[i] <= res[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= burst_q[head_q];
    end
  end

  // The burst register never claims more words than it holds.
  `B64C_ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntWidth'(BurstDepth), "burst count overflow")
  // An encoded word either only gathers or completes a whole group of four.
  `B64C_ASSERT_NEXT(a_enc_group, clk_i, rst_ni, in_acc && mode_q, cnt_q == '0 || cnt_q == CntWidth'(BurstDepth), "encoder burst is not zero or four words")
  // The last word of a message always gives at least one result.
  `B64C_ASSERT_NEXT(a_last_result, clk_i, rst_ni, in_acc && in_word_i.in_last, cnt_q != '0, "message end gave no result")

endmodule

`default_nettype wire

### verif/base64_codec_unit_test.sv
`default_nettype none

module base64_codec_unit_test
  import b64c_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // The run is ended by the watchdog if the codec stops making progress.
  // This limit is many times the slowest legal run.
  localparam int unsigned CycleLimit = 400000;
  // Cycles allowed for the burst and output registers to settle once the
  // last awaited word has been seen.
  localparam int unsigned SettleCycles = 6;
  // Words of random stimulus in each phase.
  localparam int unsigned PhaseWords = 27;
  // The mode register sits at byte address four times its register index.
  localparam logic [2:0] ModeAddr = 3'(4 * RegEncodeMode);

  typedef logic [7:0] octet_q_t[$];

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  b64c_in_t    in_word_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  b64c_out_t   out_word_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  // Percentages of cycles in which the sender holds back a word and the
  // receiver refuses one. They change from phase to phase.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned words_sent     = 0;
  int unsigned cycle_count    = 0;

  base64_codec_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #2 clk_i = ~clk_i;

  // Six-bit value to its alphabet character.
  function automatic logic [7:0] sextet_char(logic [5:0] v);
    string abc;
    abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    return abc[v];
  endfunction

  // Alphabet character to its six-bit value, or -1 for anything else.
  function automatic int char_sextet(logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - 65;
    if (c >= "a" && c <= "z") return int'(c) - 97 + 26;
    if (c >= "0" && c <= "9") return int'(c) - 48 + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  // Mirror of the codec: it keeps its own copy of the mode and the message
  // state, works out the words that each accepted input word must produce,
  // and checks the output words against them in order.
  class codec_mirror;
    bit           encoding;
    logic [15:0]  held;
    logic [1:0]   slot;
    logic [7:0]   part;
    b64c_phase_e  phase;
    b64c_status_e err;
    b64c_out_t    awaited[$];
    int unsigned  faults;

    function new();
      encoding = 1'b1;
      faults   = 0;
      clear();
    endfunction

    function void clear();
      held  = '0;
      slot  = '0;
      part  = '0;
      phase = PH_LEAD;
      err   = ST_OK;
    endfunction

    function void set_mode(bit m);
      encoding = m;
      clear();
    endfunction

    function void push(logic [7:0] b, logic valid, logic last, b64c_status_e st);
      b64c_out_t w;
      w.out_byte  = b;
      w.out_valid = valid;
      w.out_last  = last;
      w.status    = st;
      awaited.push_back(w);
    endfunction

    function void encode_byte(logic [7:0] b, logic last);
      int unsigned count;
      logic [7:0]  b0, b1, b2;
      count = (slot >= 2'd2) ? 3 : int'(slot) + 1;
      if (count < 3 && !last) begin
        held = {held[7:0], b};
        slot = 2'(count);
        return;
      end
      b1 = '0;
      b2 = '0;
      case (count)
        1: b0 = b;
        2: begin
          b0 = held[7:0];
          b1 = b;
        end
        default: begin
          b0 = held[15:8];
          b1 = held[7:0];
          b2 = b;
        end
      endcase
      push(sextet_char(b0[7:2]), 1'b1, 1'b0, ST_OK);
      push(sextet_char({b0[1:0], b1[7:4]}), 1'b1, 1'b0, ST_OK);
      push((count >= 2) ? sextet_char({b1[3:0], b2[7:6]}) : PadChar, 1'b1, 1'b0, ST_OK);
      push((count == 3) ? sextet_char(b2[5:0]) : PadChar, 1'b1, last, ST_OK);
      held = '0;
      slot = '0;
      if (last) clear();
    endfunction

    function void give_up(b64c_status_e code);
      if (err == ST_OK) err = code;
      phase = PH_DONE;
    endfunction

    function void close_text();
      if (phase == PH_DATA && slot != 2'd0) give_up(ST_INCOMPLETE);
      else if (phase == PH_PAD2) give_up(ST_INCOMPLETE);
      else if (phase == PH_TAIL && part != 8'h00) give_up(ST_LEFTOVER);
      phase = PH_DONE;
    endfunction

    function void decode_char(logic [7:0] c);
      int         v;
      logic [5:0] s;
      if (phase == PH_DONE) return;
      if (phase == PH_LEAD) begin
        if (c == CharSpace || c == CharTab) return;
        if (c == CharNul) begin
          close_text();
          return;
        end
        phase = PH_DATA;
      end
      if (c == CharSpace || c == CharTab || c == CharNul) begin
        close_text();
        return;
      end
      if (c inside {CharLf, CharVt, CharFf, CharCr}) return;
      if (phase == PH_PAD2) begin
        if (c == PadChar) phase = PH_TAIL;
        else give_up(ST_PAD);
        return;
      end
      if (phase == PH_TAIL) begin
        give_up(ST_PAD);
        return;
      end
      if (c == PadChar) begin
        if (slot == 2'd2) phase = PH_PAD2;
        else if (slot == 2'd3) phase = PH_TAIL;
        else give_up(ST_PAD);
        return;
      end
      v = char_sextet(c);
      if (v < 0) begin
        give_up(ST_BADCHAR);
        return;
      end
      s = v[5:0];
      case (slot)
        2'd0: begin
          part = {s, 2'b00};
          slot = 2'd1;
        end
        2'd1: begin
          push(part | {6'b0, s[5:4]}, 1'b1, 1'b0, ST_OK);
          part = {s[3:0], 4'b0};
          slot = 2'd2;
        end
        2'd2: begin
          push(part | {4'b0, s[5:2]}, 1'b1, 1'b0, ST_OK);
          part = {s[1:0], 6'b0};
          slot = 2'd3;
        end
        default: begin
          push(part | {2'b0, s}, 1'b1, 1'b0, ST_OK);
          part = '0;
          slot = 2'd0;
        end
      endcase
    endfunction

    // Called for every input word that the codec accepts.
    function void take_word(b64c_in_t w);
      if (encoding) begin
        encode_byte(w.in_byte, w.in_last);
        return;
      end
      decode_char(w.in_byte);
      if (w.in_last) begin
        if (phase != PH_DONE) close_text();
        push(8'h00, 1'b0, 1'b1, err);
        clear();
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        faults++;
      end
    endfunction

    // Called for every output word that the testbench accepts.
    function void check_word(b64c_out_t got);
      b64c_out_t want;
      if (awaited.size() == 0) begin
        $error("output word %h arrived with nothing awaited", got);
        faults++;
        return;
      end
      want = awaited.pop_front();
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("out_valid", 8'(want.out_valid), 8'(got.out_valid));
      compare_field("out_last", 8'(want.out_last), 8'(got.out_last));
      compare_field("status", 8'(want.status), 8'(got.status));
    endfunction
  endclass

  codec_mirror mirror = new();

  // Watchdog: a run that hangs is a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver. Output words are sampled at the clock edge, before any of the
  // codec's registers change, and out_ready_i is refused at random in the
  // proportion that the current phase asks for.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) mirror.check_word(out_word_o);
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offers one word and returns at the edge at which it is accepted. Any
  // idle cycles come first, so a word that follows straight on keeps valid
  // high without it being lowered in between.
  task automatic send_word(logic [7:0] b, logic last);
    b64c_in_t w;
    w.in_byte = b;
    w.in_last = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    mirror.take_word(w);
    words_sent++;
  endtask

  // Sends a whole message, marking its final word as last.
  task automatic send_message(octet_q_t msg);
    for (int i = 0; i < msg.size(); i++) send_word(msg[i], i == msg.size() - 1);
  endtask

  function automatic octet_q_t octets(string s);
    octet_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // Waits until every awaited word has come out and the codec has settled.
  task automatic drain();
    while (mirror.awaited.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes the mode register with a setup and an access cycle, then reads
  // it back. The mirror follows the write at the edge at which it lands.
  task automatic write_mode(bit m);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ModeAddr;
    pwdata  <= 32'(m);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    mirror.set_mode(m);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(m)) begin
      $error("prdata: expected %0h, got %0h", 32'(m), prdata);
      mirror.faults++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Raw bytes for the encoder: short messages of any content, so that every
  // group length and every message length modulo three is reached.
  task automatic random_byte_message();
    octet_q_t msg;
    repeat ($urandom_range(1, 9)) msg.push_back(8'($urandom));
    send_message(msg);
  endtask

  // Text for the decoder. Most messages are well-formed Base64 of random
  // content, possibly with leading blanks and embedded line breaks; the rest
  // are damaged so that each error path is taken: a corrupted character, a
  // message cut short, a terminator with trailing junk, a stray character
  // after the pad, or nonzero bits left over before the pad.
  task automatic random_text_message();
    octet_q_t   msg;
    int         quanta, tail, idx;
    bit         sloppy;
    logic [5:0] s;
    logic [7:0] c;
    repeat ($urandom_range(2)) msg.push_back($urandom_range(1) ? CharSpace : CharTab);
    quanta = $urandom_range(2);
    tail   = $urandom_range(2);
    sloppy = ($urandom_range(3) == 0);
    repeat (quanta * 4) msg.push_back(sextet_char(6'($urandom_range(63))));
    if (tail != 0) begin
      msg.push_back(sextet_char(6'($urandom_range(63))));
      if (tail == 2) msg.push_back(sextet_char(6'($urandom_range(63))));
      // The character before the pad must have its low bits clear to be
      // well formed; a sloppy message leaves them random.
      s = 6'($urandom_range(63));
      if (!sloppy) s &= (tail == 1) ? 6'h30 : 6'h3c;
      msg.push_back(sextet_char(s));
      msg.push_back(PadChar);
      if (tail == 1) msg.push_back(PadChar);
    end
    if (msg.size() == 0) msg.push_back(sextet_char(6'($urandom_range(63))));
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0: c = CharLf;
        1: c = CharVt;
        2: c = CharFf;
        default: c = CharCr;
      endcase
      idx = $urandom_range(msg.size());
      msg.insert(idx, c);
    end
    case ($urandom_range(11))
      0, 1: begin
        idx = $urandom_range(msg.size() - 1);
        msg[idx] = 8'($urandom);
      end
      2: begin
        repeat ($urandom_range(1, 3)) if (msg.size() > 1) void'(msg.pop_back());
      end
      3: begin
        case ($urandom_range(2))
          0: msg.push_back(CharSpace);
          1: msg.push_back(CharTab);
          default: msg.push_back(CharNul);
        endcase
        msg.push_back(8'($urandom));
      end
      4: msg.push_back(8'($urandom));
      default: ;
    endcase
    send_message(msg);
  endtask

  initial begin
    octet_q_t    msg;
    int unsigned start;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Four idling phases, each run once in encode mode and once in decode
    // mode. The first phase has no idling at all and carries the directed
    // messages.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 79;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 79;
        end
        default: begin
          send_idle_pct  = 27;
          recv_stall_pct = 27;
        end
      endcase
      for (int m = 1; m >= 0; m--) begin
        drain();
        write_mode(m[0]);
        if (p == 0 && m == 1) begin
          // One, two and three byte groups, all-zero and all-one bytes, and
          // groups that yield '+' and '/'.
          msg = '{8'h00};
          send_message(msg);
          msg = '{8'hff, 8'hff};
          send_message(msg);
          msg = '{8'hfb, 8'hef, 8'hbe};
          send_message(msg);
          msg = '{8'h4d, 8'h61, 8'h6e, 8'h80};
          send_message(msg);
          msg = '{8'h01, 8'h02, 8'h03, 8'hfe, 8'h7f};
          send_message(msg);
        end
        if (p == 0 && m == 0) begin
          // Leading blanks before a padded quantum.
          send_message(octets(" \tQQ=="));
          // A lone NUL: empty text, which is fine.
          msg = '{CharNul};
          send_message(msg);
          // Pad in the first position.
          send_message(octets("="));
          // Something other than a second pad after a third-position pad.
          send_message(octets("QQ=A"));
          // Nonzero bits left over under a double pad.
          send_message(octets("QR=="));
          // Text ending after a single third-position pad.
          send_message(octets("QQ="));
          // A line break is skipped; a byte above 0x7f is a bad character.
          msg = octets("Q\n");
          msg.push_back(8'hff);
          send_message(msg);
          // A space ends a partial quantum and the rest is ignored.
          send_message(octets("/+8 x"));
        end
        start = words_sent;
        while (words_sent - start < PhaseWords) begin
          if (m == 1) random_byte_message();
          else random_text_message();
        end
        in_valid_i <= 1'b0;
      end
    end

    drain();
    if (mirror.faults == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
